// ----- hdl/tfb_pkg.sv -----
`timescale 1ns / 1ps
// tfb_pkg: types and constants shared by the frame builder modules
// no dependencies

package tfb_pkg;

	localparam logic [7:0] HDR_BYTE      = 8'hAA;
	localparam logic [7:0] ADDR_BCAST    = 8'hFF;
	localparam logic [7:0] FUNC_VALUES   = 8'hF1;
	localparam logic [7:0] FUNC_ATTITUDE = 8'h03;
	localparam logic [7:0] FUNC_SPEED    = 8'hF2;

	localparam logic [3:0] LEN_VALUES   = 4'd8;
	localparam logic [3:0] LEN_ATTITUDE = 4'd7;
	localparam logic [3:0] LEN_SPEED    = 4'd1;

	localparam logic [1:0] OP_VALUES   = 2'd0;
	localparam logic [1:0] OP_ATTITUDE = 2'd1;
	localparam logic [1:0] OP_SPEED    = 2'd2;
	localparam logic [1:0] OP_NONE     = 2'd3;

	// fixed byte positions at the head of a frame
	localparam logic [3:0] IDX_HDR  = 4'd0;
	localparam logic [3:0] IDX_ADDR = 4'd1;
	localparam logic [3:0] IDX_FUNC = 4'd2;
	localparam logic [3:0] IDX_LEN  = 4'd3;
	localparam logic [3:0] IDX_PAY  = 4'd4;

	typedef struct packed {
		logic        [1:0]  opcode;
		logic signed [15:0] word_a;
		logic signed [15:0] word_b;
		logic signed [31:0] word_c;
		logic        [7:0]  status_byte;
	} tfb_req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} tfb_rsp_t;

	// one classified frame: function code, payload length, payload bytes (byte 0 lowest)
	typedef struct packed {
		logic [7:0]  func;
		logic [3:0]  len;
		logic [63:0] payload;
	} tfb_desc_t;

endpackage

// ----- hdl/tfb_front.sv -----
`timescale 1ns / 1ps
// tfb_front: accepts requests, drops unused opcodes, builds frame descriptors
// depends on tfb_pkg

module tfb_front import tfb_pkg::*; (
	input  logic      req_valid,
	output logic      req_stall,
	input  tfb_req_t  req,
	output logic      push,
	output tfb_desc_t push_desc,
	input  logic      q_full
);

	assign req_stall = q_full;
	assign push      = req_valid && !q_full && (req.opcode != OP_NONE);

	always_comb begin
		push_desc = '0;
		case (req.opcode)
			OP_VALUES: begin
				push_desc.func    = FUNC_VALUES;
				push_desc.len     = LEN_VALUES;
				push_desc.payload = {req.word_c, req.word_b, req.word_a};
			end
			OP_ATTITUDE: begin
				push_desc.func    = FUNC_ATTITUDE;
				push_desc.len     = LEN_ATTITUDE;
				push_desc.payload = {8'h00, req.status_byte, req.word_c[15:0],
					req.word_b, req.word_a};
			end
			OP_SPEED: begin
				push_desc.func    = FUNC_SPEED;
				push_desc.len     = LEN_SPEED;
				push_desc.payload = {56'h0, req.status_byte};
			end
			default: begin
				push_desc = '0;
			end
		endcase
	end

endmodule

// ----- hdl/tfb_queue.sv -----
`timescale 1ns / 1ps
// tfb_queue: small register queue of frame descriptors between front and back
// depends on tfb_pkg

module tfb_queue import tfb_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tfb_desc_t push_desc,
	output logic      full,
	input  logic      pop,
	output logic      q_valid,
	output tfb_desc_t q_desc
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tfb_desc_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign q_valid = (cnt_q != '0);
	assign q_desc  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

// ----- hdl/tfb_back.sv -----
`timescale 1ns / 1ps
// tfb_back: walks one descriptor byte by byte, keeps the running checks,
// and holds each beat in an output register; depends on tfb_pkg

module tfb_back import tfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] target,
	input  logic       q_valid,
	input  tfb_desc_t  q_desc,
	output logic       pop,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output tfb_rsp_t   rsp
);

	tfb_desc_t  desc_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic [7:0] sum_q;
	logic [7:0] add_q;
	logic       out_valid_q;
	tfb_rsp_t   out_q;

	logic       emit;
	logic       is_last;
	logic       is_data;
	logic [3:0] sum_idx;
	logic [3:0] last_idx;
	logic [3:0] pay_off;
	logic [7:0] cur_byte;
	logic [7:0] sum_n;

	assign sum_idx  = desc_q.len + IDX_PAY;
	assign last_idx = sum_idx + 4'd1;
	assign pay_off  = idx_q - IDX_PAY;
	assign emit     = busy_q && (!out_valid_q || !rsp_stall);
	assign is_last  = (idx_q == last_idx);
	assign is_data  = (idx_q < sum_idx);
	assign pop      = q_valid && (!busy_q || (emit && is_last));
	assign sum_n    = sum_q + cur_byte;

	always_comb begin
		if (idx_q == IDX_HDR) begin
			cur_byte = HDR_BYTE;
		end else if (idx_q == IDX_ADDR) begin
			cur_byte = target;
		end else if (idx_q == IDX_FUNC) begin
			cur_byte = desc_q.func;
		end else if (idx_q == IDX_LEN) begin
			cur_byte = {4'h0, desc_q.len};
		end else if (idx_q == sum_idx) begin
			cur_byte = sum_q;
		end else if (idx_q == last_idx) begin
			cur_byte = add_q;
		end else begin
			cur_byte = desc_q.payload[{pay_off[2:0], 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			sum_q       <= '0;
			add_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				sum_q  <= '0;
				add_q  <= '0;
			end else if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				idx_q <= idx_q + 4'd1;
				// checks cover header through payload only
				if (is_data) begin
					sum_q <= sum_n;
					add_q <= add_q + sum_n;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= q_desc;
		end
		if (emit) begin
			out_q.frame_byte <= cur_byte;
			out_q.last_byte  <= is_last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- hdl/telemetry_frame_builder_core.sv -----
`timescale 1ns / 1ps
// telemetry_frame_builder_core: frame builder top; request front, descriptor
// queue, byte emitter and the target address register; depends on tfb_pkg
// a request passes the descriptor queue and the emitter's descriptor register before its first beat
// throughput: one frame byte per cycle while rsp_stall is low; frames are 14, 13 or 7 bytes
// long; opcode 3 is taken with no output
// reset: arst_n clears queue and emitter, target address resets to 0xFF

module telemetry_frame_builder_core import tfb_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  tfb_req_t   req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output tfb_rsp_t   rsp,
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata
);

	logic [7:0] target_q;
	logic       push;
	tfb_desc_t  push_desc;
	logic       q_full;
	logic       pop;
	logic       q_valid;
	tfb_desc_t  q_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ADDR_BCAST;
		end else if (cfg_wen) begin
			target_q <= cfg_wdata;
		end
	end

	tfb_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	tfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_desc    (q_desc)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.target    (target_q),
		.q_valid   (q_valid),
		.q_desc    (q_desc),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- tb/telemetry_frame_builder_checker.sv -----
`timescale 1ns / 1ps
// telemetry_frame_builder_checker: watches request, response and config ports,
// predicts every frame byte and compares beats in order; depends on tfb_pkg

module telemetry_frame_builder_checker import tfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  tfb_req_t    req,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  tfb_rsp_t    rsp,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	output int unsigned fail_count,
	output int unsigned pending
);

	localparam int unsigned REPORT_LIMIT = 10;

	logic [7:0]  target_addr;
	tfb_rsp_t    frame_bytes_q[$];
	int unsigned mismatches;

	task automatic predict_frame(input tfb_req_t r);
		logic [7:0] fb[0:13];
		logic [7:0] sum;
		logic [7:0] add;
		tfb_rsp_t   beat;
		int         n;
		n = 0;
		fb[0] = HDR_BYTE;
		fb[1] = target_addr;
		case (r.opcode)
			OP_VALUES: begin
				fb[2]  = FUNC_VALUES;
				fb[3]  = 8'(LEN_VALUES);
				fb[4]  = r.word_a[7:0];
				fb[5]  = r.word_a[15:8];
				fb[6]  = r.word_b[7:0];
				fb[7]  = r.word_b[15:8];
				fb[8]  = r.word_c[7:0];
				fb[9]  = r.word_c[15:8];
				fb[10] = r.word_c[23:16];
				fb[11] = r.word_c[31:24];
				n = 12;
			end
			OP_ATTITUDE: begin
				fb[2]  = FUNC_ATTITUDE;
				fb[3]  = 8'(LEN_ATTITUDE);
				fb[4]  = r.word_a[7:0];
				fb[5]  = r.word_a[15:8];
				fb[6]  = r.word_b[7:0];
				fb[7]  = r.word_b[15:8];
				// yaw is the low half of word_c only
				fb[8]  = r.word_c[7:0];
				fb[9]  = r.word_c[15:8];
				fb[10] = r.status_byte;
				n = 11;
			end
			OP_SPEED: begin
				fb[2] = FUNC_SPEED;
				fb[3] = 8'(LEN_SPEED);
				fb[4] = r.status_byte;
				n = 5;
			end
			default: begin
				n = 0;
			end
		endcase
		if (n != 0) begin
			sum = 8'h00;
			add = 8'h00;
			for (int i = 0; i < n; i++) begin
				sum = sum + fb[i];
				add = add + sum;
			end
			fb[n]     = sum;
			fb[n + 1] = add;
			n = n + 2;
			for (int i = 0; i < n; i++) begin
				beat.frame_byte = fb[i];
				beat.last_byte  = (i == n - 1);
				frame_bytes_q.push_back(beat);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tfb_rsp_t want;
		if (!arst_n) begin
			target_addr <= ADDR_BCAST;
			frame_bytes_q.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// response beats first: a request taken this edge cannot answer yet
			if (rsp_valid && !rsp_stall) begin
				if (frame_bytes_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected beat: byte %02h last %0d",
							rsp.frame_byte, rsp.last_byte);
				end else begin
					want = frame_bytes_q.pop_front();
					if (rsp.frame_byte !== want.frame_byte ||
							rsp.last_byte !== want.last_byte) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("beat mismatch: expected byte %02h last %0d, got byte %02h last %0d",
								want.frame_byte, want.last_byte,
								rsp.frame_byte, rsp.last_byte);
					end
				end
			end
			if (req_valid && !req_stall)
				predict_frame(req);
			if (cfg_wen)
				target_addr <= cfg_wdata;
			fail_count <= mismatches;
			pending    <= frame_bytes_q.size();
		end
	end

endmodule

// ----- tb/telemetry_frame_builder_core_tb.sv -----
`timescale 1ns / 1ps
// telemetry_frame_builder_core_tb: clock, reset, request and config stimulus,
// response stall pattern and verdict; depends on tfb_pkg, the core and the checker

module telemetry_frame_builder_core_tb;
	import tfb_pkg::*;

	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int          ITEMS_PER_PHASE = 50;

	localparam logic [1:0] STALL_NONE   = 2'd0;
	localparam logic [1:0] STALL_LIGHT  = 2'd1;
	localparam logic [1:0] STALL_HEAVY  = 2'd2;
	localparam logic [1:0] STALL_PERIOD = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	tfb_req_t    req;
	logic        rsp_valid;
	logic        rsp_stall;
	tfb_rsp_t    rsp;
	logic        cfg_wen;
	logic [7:0]  cfg_wdata;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned idle_cycles;
	int unsigned burst_left;
	logic [1:0]  stall_mode;
	int unsigned stall_left;
	int unsigned stall_phase;

	telemetry_frame_builder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	telemetry_frame_builder_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		req_valid   = 1'b0;
		req         = '0;
		rsp_stall   = 1'b0;
		cfg_wen     = 1'b0;
		cfg_wdata   = 8'h00;
		stall_mode  = STALL_NONE;
		stall_left  = 0;
		stall_phase = 0;
		burst_left  = 0;
	end

	// receiver stall: randomly chosen modes, none, light, heavy or periodic
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = 2'($urandom_range(STALL_NONE, STALL_PERIOD));
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left--;
		end
		stall_phase++;
		case (stall_mode)
			STALL_NONE:   rsp_stall = 1'b0;
			STALL_LIGHT:  rsp_stall = ($urandom_range(0, 9) < 3);
			STALL_HEAVY:  rsp_stall = ($urandom_range(0, 9) < 7);
			default:      rsp_stall = (stall_phase % 3 == 0);
		endcase
	end

	// watchdog: only counts while something is offered or owed
	always @(posedge clk) begin
		if (arst_n && (req_valid || pending != 0) &&
				!(req_valid && !req_stall) && !(rsp_valid && !rsp_stall)) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

	function automatic tfb_req_t make_req(input logic [1:0] op, input logic [15:0] a,
			input logic [15:0] b, input logic [31:0] c, input logic [7:0] s);
		tfb_req_t r;
		r.opcode      = op;
		r.word_a      = a;
		r.word_b      = b;
		r.word_c      = c;
		r.status_byte = s;
		return r;
	endfunction

	function automatic logic [15:0] pick_half();
		case ($urandom_range(0, 11))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h8000;
			3:       return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic tfb_req_t random_req();
		logic [1:0]  op;
		logic [31:0] c;
		op = ($urandom_range(0, 9) == 0) ? OP_NONE : 2'($urandom_range(OP_VALUES, OP_SPEED));
		case ($urandom_range(0, 9))
			0:       c = 32'h8000_0000;
			1:       c = 32'h7FFF_FFFF;
			2:       c = 32'hFFFF_FFFF;
			default: c = $urandom;
		endcase
		return make_req(op, pick_half(), pick_half(), c, 8'($urandom));
	endfunction

	// one request beat; valid stays high inside a burst
	task automatic send_request(input tfb_req_t r);
		int unsigned gap;
		@(negedge clk);
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				req_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic [7:0] addr);
		drain();
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_wdata = addr;
		@(negedge clk);
		cfg_wen   = 1'b0;
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			send_request(random_req());
			if ($urandom_range(0, 19) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed beats at the reset address
		send_request(make_req(OP_VALUES, 16'h8000, 16'h7FFF, 32'h8000_0000, 8'h00));
		send_request(make_req(OP_VALUES, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 8'hFF));
		send_request(make_req(OP_VALUES, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00));
		send_request(make_req(OP_VALUES, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
		send_request(make_req(OP_ATTITUDE, 16'h8000, 16'h7FFF, 32'h1234_8000, 8'h00));
		send_request(make_req(OP_ATTITUDE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
		send_request(make_req(OP_ATTITUDE, 16'h0000, 16'h0000, 32'hABCD_0000, 8'h5A));
		send_request(make_req(OP_SPEED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'h00));
		send_request(make_req(OP_SPEED, 16'h0000, 16'h0000, 32'h0000_0000, 8'hFF));
		// unused opcode, alone, back to back and followed by a frame
		send_request(make_req(OP_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
		send_request(make_req(OP_NONE, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00));
		send_request(make_req(OP_SPEED, 16'h1234, 16'h5678, 32'h9ABC_DEF0, 8'h80));
		send_request(make_req(OP_NONE, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 8'h55));
		send_request(make_req(OP_VALUES, 16'h0102, 16'h0304, 32'h0506_0708, 8'h09));

		write_target(8'h00);
		random_phase(ITEMS_PER_PHASE);
		write_target(8'hFF);
		random_phase(ITEMS_PER_PHASE);
		write_target(8'($urandom));
		random_phase(ITEMS_PER_PHASE);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- telemetry_frame_builder_core.f -----
hdl/tfb_pkg.sv
hdl/tfb_front.sv
hdl/tfb_queue.sv
hdl/tfb_back.sv
hdl/telemetry_frame_builder_core.sv
tb/telemetry_frame_builder_checker.sv
tb/telemetry_frame_builder_core_tb.sv
